### design/lsrt_pkg.sv
// Shared types, constants and command codes for the link-state route table.
// No dependencies; imported by the top level, the datapath and the controller.
package lsrt_pkg;
    localparam int MAX_NODES = 64;
    localparam int COST_BITS = 16;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int PATH_W    = 22;
    localparam int MAT_AW    = 2 * NODE_W;
    localparam int LINK_W    = COST_BITS + 1;
    localparam int SUM_W     = PATH_W + 1;
    localparam logic [PATH_W-1:0] PATH_MAX = {PATH_W{1'b1}};

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_ROUTE = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic              init;      // start compute from src
        logic              scan;      // examine node j for selection
        logic              pick;      // commit selection
        logic              rd_link;   // read matrix (pick,j)
        logic              relax;     // relax node j with read data
        logic              emit;      // load output row j
        logic              mat_we;    // matrix write
        logic [MAT_AW-1:0] mat_addr;
        logic [LINK_W-1:0] mat_wdata;
        logic [NODE_W-1:0] j;
        logic [NODE_W-1:0] src;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] pick;      // node committed by the last pick
    } t_stat;
endpackage

### design/link_state_route_table_core.sv
// Link-state route table top level: APB register, stream ports, ctrl + datapath.
// Depends on lsrt_pkg, lsrt_ctrl, lsrt_datapath.
// Throughput: one command at a time; route time set by the single matrix read port.
// Reset: synchronous active low; a matrix clearing pass follows reset.
module link_state_route_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // command, node_a, node_b, link_cost, link_up
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // dest_node, first_hop, path_cost, reachable
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lsrt_pkg::*;

    logic [6:0] r_active;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [NODE_W-1:0] w_hop, w_dest;
    logic [PATH_W-1:0] w_cost;
    logic w_reach;

    assign pready = 1'b1;
    assign prdata = {25'd0, r_active};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_active <= 7'd64;
        else if (psel && penable && pwrite && paddr == 1'b0) r_active <= pwdata[6:0];
    end

    lsrt_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_command(s_axis_tdata[1:0]), .i_node_a(s_axis_tdata[7:2]),
        .i_node_b(s_axis_tdata[13:8]), .i_link_cost(s_axis_tdata[29:14]),
        .i_link_up(s_axis_tdata[30]), .i_active(r_active),
        .i_stat(w_stat), .o_cmd(w_cmd),
        .o_row_valid(m_axis_tvalid), .i_row_ready(m_axis_tready),
        .o_row_dest(w_dest), .o_row_last(m_axis_tlast)
    );

    lsrt_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_stat(w_stat),
        .o_row_hop(w_hop), .o_row_cost(w_cost), .o_row_reach(w_reach)
    );

    assign m_axis_tdata = {5'd0, w_reach, w_cost, w_hop, w_dest};
endmodule

### design/lsrt_datapath.sv
// Datapath: link matrix memory, distance/hop tables, selection and relaxation.
// Depends on lsrt_pkg.
module lsrt_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lsrt_pkg::t_cmd         i_cmd,
    output lsrt_pkg::t_stat        o_stat,
    output logic [lsrt_pkg::NODE_W-1:0] o_row_hop,
    output logic [lsrt_pkg::PATH_W-1:0] o_row_cost,
    output logic                   o_row_reach
);
    import lsrt_pkg::*;

    logic [LINK_W-1:0] r_mat [0:MAX_NODES*MAX_NODES-1];
    logic [LINK_W-1:0] r_link;
    logic [PATH_W-1:0] r_dist [0:MAX_NODES-1];
    logic [NODE_W-1:0] r_hop  [0:MAX_NODES-1];
    logic [MAX_NODES-1:0] r_done, r_reach;
    logic              r_found;
    logic [NODE_W-1:0] r_pick, r_cand;
    logic [PATH_W-1:0] r_pdist, r_cdist;
    logic [PATH_W-1:0] r_jdist;
    logic [NODE_W-1:0] r_jhop, r_phop;
    logic [SUM_W-1:0]  w_sum;
    logic [PATH_W-1:0] w_sat;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mat_we) r_mat[i_cmd.mat_addr] <= i_cmd.mat_wdata;
        if (i_cmd.rd_link) r_link <= r_mat[i_cmd.mat_addr];
        r_jdist <= r_dist[i_cmd.j];
        r_jhop  <= r_hop[i_cmd.j];
    end

    assign w_sum = {1'b0, r_pdist} + SUM_W'(r_link[LINK_W-1:1]);
    assign w_sat = w_sum[SUM_W-1] ? PATH_MAX : w_sum[PATH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= '0;
            r_reach <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.init) begin
            r_done  <= '0;
            r_reach <= '0;
            r_reach[i_cmd.src] <= 1'b1;
            r_found <= 1'b0;
        end else if (i_cmd.scan) begin
            // strict less keeps the lowest index on ties
            if (!r_done[i_cmd.j] && r_reach[i_cmd.j] &&
                (!r_found || r_jdist < r_cdist)) begin
                r_found <= 1'b1;
                r_cand  <= i_cmd.j;
                r_cdist <= r_jdist;
            end
        end else if (i_cmd.pick) begin
            r_done[r_cand] <= 1'b1;
            r_pick  <= r_cand;
            r_pdist <= r_cdist;
            r_phop  <= r_hop[r_cand];
            r_found <= 1'b0;
        end else if (i_cmd.relax) begin
            if (!r_done[i_cmd.j] && r_link[0] &&
                (!r_reach[i_cmd.j] || w_sat < r_jdist))
                r_reach[i_cmd.j] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_dist[i_cmd.src] <= '0;
            r_hop[i_cmd.src]  <= i_cmd.src;
        end else if (i_cmd.relax && !r_done[i_cmd.j] && r_link[0] &&
                     (!r_reach[i_cmd.j] || w_sat < r_jdist)) begin
            r_dist[i_cmd.j] <= w_sat;
            r_hop[i_cmd.j]  <= (r_pick == i_cmd.src) ? i_cmd.j : r_phop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_row_reach <= r_reach[i_cmd.j];
            o_row_hop   <= r_reach[i_cmd.j] ? r_jhop : '0;
            o_row_cost  <= r_reach[i_cmd.j] ? r_jdist : '0;
        end
    end

    assign o_stat.found = r_found;
    assign o_stat.pick  = r_pick;
endmodule

### design/lsrt_ctrl.sv
// Controller: command decode, matrix clear sweep and Dijkstra sequencing.
// Depends on lsrt_pkg.
module lsrt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_command,
    input  logic [lsrt_pkg::NODE_W-1:0] i_node_a,
    input  logic [lsrt_pkg::NODE_W-1:0] i_node_b,
    input  logic [15:0]                 i_link_cost,
    input  logic                        i_link_up,
    input  logic [6:0]                  i_active,
    input  lsrt_pkg::t_stat             i_stat,
    output lsrt_pkg::t_cmd              o_cmd,
    output logic                        o_row_valid,
    input  logic                        i_row_ready,
    output logic [lsrt_pkg::NODE_W-1:0] o_row_dest,
    output logic                        o_row_last
);
    import lsrt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0, S_CLR  = 4'd1, S_SET2 = 4'd2,
                           S_SCANR = 4'd3, S_SCAN = 4'd4, S_PICK = 4'd5,
                           S_RD    = 4'd6, S_REL  = 4'd7, S_EMR  = 4'd8,
                           S_EM    = 4'd9, S_OUT  = 4'd10, S_RELW = 4'd11;

    logic [3:0]        r_st;
    logic [MAT_AW-1:0] r_ctr;
    logic [NODE_W-1:0] r_j, r_src, r_a, r_b, r_last;
    logic [CNT_W-1:0]  r_step;
    logic [LINK_W-1:0] r_word;
    logic [CNT_W-1:0]  w_n;
    logic              w_acc;

    always_comb begin
        if (i_active == 7'd0) w_n = CNT_W'(1);
        else if ({1'b0, i_active} > 8'(MAX_NODES)) w_n = CNT_W'(MAX_NODES);
        else w_n = CNT_W'(i_active);
    end

    assign o_in_ready = (r_st == S_IDLE) && i_rst_n;
    assign w_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_CLR;
            r_ctr <= '0;
            o_row_valid <= 1'b0;
        end else begin
            case (r_st)
                S_IDLE: if (w_acc) begin
                    r_a <= i_node_a;
                    r_b <= i_node_b;
                    r_src <= i_node_a;
                    r_last <= NODE_W'(w_n - CNT_W'(1));
                    r_word <= i_link_up ? {i_link_cost[COST_BITS-1:0], 1'b1} : '0;
                    case (i_command)
                        CMD_SET:   r_st <= S_SET2;
                        CMD_CLEAR: begin r_st <= S_CLR; r_ctr <= '0; end
                        CMD_ROUTE: if (CNT_W'(i_node_a) < w_n) begin
                            r_st <= S_SCANR; r_j <= '0; r_step <= '0;
                        end
                        default: r_st <= S_IDLE;
                    endcase
                end
                S_CLR: begin
                    r_ctr <= r_ctr + 1'b1;
                    if (r_ctr == '1) r_st <= S_IDLE;
                end
                S_SET2: r_st <= S_IDLE;
                S_SCANR: r_st <= S_SCAN;
                S_SCAN: begin
                    if (r_j == r_last) begin r_st <= S_PICK; r_j <= '0; end
                    else begin r_j <= r_j + 1'b1; r_st <= S_SCANR; end
                end
                S_PICK: begin
                    if (!i_stat.found) r_st <= S_EMR;
                    else r_st <= S_RD;
                    r_step <= r_step + 1'b1;
                end
                S_RD: r_st <= S_RELW;
                S_RELW: r_st <= S_REL;
                S_REL: begin
                    if (r_j == r_last) begin
                        r_j <= '0;
                        r_st <= (r_step == w_n) ? S_EMR : S_SCANR;
                    end else begin
                        r_j <= r_j + 1'b1; r_st <= S_RD;
                    end
                end
                S_EMR: r_st <= S_EM;
                S_EM: begin r_st <= S_OUT; o_row_valid <= 1'b1; end
                S_OUT: if (i_row_ready) begin
                    o_row_valid <= 1'b0;
                    if (r_j == r_last) r_st <= S_IDLE;
                    else begin r_j <= r_j + 1'b1; r_st <= S_EMR; end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.j   = r_j;
        o_cmd.src = r_src;
        case (r_st)
            S_IDLE: begin
                o_cmd.init = w_acc && (i_command == CMD_ROUTE);
                o_cmd.src  = i_node_a;
                o_cmd.mat_we = w_acc && (i_command == CMD_SET);
                o_cmd.mat_addr = {i_node_a, i_node_b};
                o_cmd.mat_wdata = i_link_up ? {i_link_cost[COST_BITS-1:0], 1'b1} : '0;
            end
            S_CLR: begin
                o_cmd.mat_we = 1'b1;
                o_cmd.mat_addr = r_ctr;
                o_cmd.mat_wdata = (r_ctr[MAT_AW-1:NODE_W] == r_ctr[NODE_W-1:0])
                                  ? LINK_W'(1) : '0;
            end
            S_SET2: begin
                o_cmd.mat_we = 1'b1;
                o_cmd.mat_addr = {r_b, r_a};
                o_cmd.mat_wdata = r_word;
            end
            S_SCAN: o_cmd.scan = 1'b1;
            S_PICK: o_cmd.pick = i_stat.found;
            S_RD: begin
                // read the picked node's matrix row
                o_cmd.rd_link = 1'b1;
                o_cmd.mat_addr = {i_stat.pick, r_j};
            end
            S_REL: o_cmd.relax = 1'b1;
            S_EM:  o_cmd.emit = 1'b1;
            default: ;
        endcase
    end

    assign o_row_dest = r_j;
    assign o_row_last = (r_j == r_last);
endmodule

### design/lsrt_checker.sv
// Port-level checker for the link-state route table, bound to the top level.
// Depends on link_state_route_table_core ports only.
module lsrt_checker (
    input logic i_clk, input logic i_rst_n,
    input logic s_axis_tvalid, input logic s_axis_tready,
    input logic m_axis_tvalid, input logic m_axis_tready, input logic m_axis_tlast,
    input logic pready
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("row dropped");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tlast))
        else $error("last flag moved while held");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during rows");
    a_rdy: assert property (@(posedge i_clk) pready) else $error("pready low");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("row after reset");
endmodule

bind link_state_route_table_core lsrt_checker u_chk (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tlast, .pready
);
